FILE: rtl/bcc_pkg.sv
// Shared types, constants and helper functions of the braille cell color encoder.
// Used by every module of the block; depends on nothing.
package bcc_pkg;

    // Cell text length and byte counter width
    localparam int BYTES_PER_CELL = 24;
    localparam int IDX_W          = $clog2(BYTES_PER_CELL);

    // Register reset: empty braille pattern
    localparam logic [15:0] CHAR_BASE_RESET = 16'h2800;

    // Averaging arithmetic: sum of eight bytes, reciprocal 2^18/count rounded up
    localparam int SUM_W       = 11;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [7:0] WHITE = 8'd255;

    // Fixed characters of the escape sequence
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PAD   = 8'h00;

    // UTF-8 three-byte framing
    localparam logic [7:0] UTF8_LEAD = 8'hE0;
    localparam logic [7:0] UTF8_CONT = 8'h80;

    // Stage 1 -> stage 2: per-channel sums, lit dot count, code point
    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [CNT_W-1:0] count;
        logic [15:0]      code_point;
    } cell_sum_t;

    // Stage 2 -> stage 3: quotients and no-dot flag
    typedef struct packed {
        logic [7:0]  avg_red;
        logic [7:0]  avg_green;
        logic [7:0]  avg_blue;
        logic        no_dots;
        logic [15:0] code_point;
    } cell_avg_t;

    // Stage 3 -> serializer: three BCD digits per channel
    typedef struct packed {
        logic [11:0] dec_red;
        logic [11:0] dec_green;
        logic [11:0] dec_blue;
        logic [15:0] code_point;
    } cell_text_t;

    // ceil(2^18 / count); exact floor division for sums below 2048
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        unique case (count)
            4'd1:    r = 19'd262144;
            4'd2:    r = 19'd131072;
            4'd3:    r = 19'd87382;
            4'd4:    r = 19'd65536;
            4'd5:    r = 19'd52429;
            4'd6:    r = 19'd43691;
            4'd7:    r = 19'd37450;
            4'd8:    r = 19'd32768;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Byte to three BCD digits {hundreds, tens, ones}
    function automatic logic [11:0] to_dec(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  rem;
        logic [14:0] tp;
        logic [3:0]  t;
        logic [3:0]  o;
        priority if (v >= 8'd200)
        begin
            h   = 2'd2;
            rem = 7'(v - 8'd200);
        end
        else if (v >= 8'd100)
        begin
            h   = 2'd1;
            rem = 7'(v - 8'd100);
        end
        else
        begin
            h   = 2'd0;
            rem = v[6:0];
        end
        // rem * 205 >> 11 is rem / 10 for rem below 100
        tp = 15'(rem) * 15'd205;
        t  = tp[14:11];
        o  = 4'(rem - 7'(7'(t) * 7'd10));
        return {2'b00, h, t, o};
    endfunction

endpackage

FILE: rtl/bcc_cell_if.sv
// Input channel of the braille cell color encoder: one cell per transfer.
// Depends on nothing.
interface bcc_cell_if;
    logic        valid;
    logic        ready;
    logic [7:0]  dot_mask;
    logic [63:0] red_dots;
    logic [63:0] green_dots;
    logic [63:0] blue_dots;

    modport source (output valid, output dot_mask, output red_dots, output green_dots,
                    output blue_dots, input ready);
    modport sink   (input valid, input dot_mask, input red_dots, input green_dots,
                    input blue_dots, output ready);
endinterface

FILE: rtl/bcc_byte_if.sv
// Output channel of the braille cell color encoder: one text byte per transfer.
// Depends on nothing.
interface bcc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_cell;

    modport source (output valid, output out_byte, output last_of_cell, input ready);
    modport sink   (input valid, input out_byte, input last_of_cell, output ready);
endinterface

FILE: rtl/bcc_cfg_if.sv
// Configuration write channel of the braille cell color encoder (char_base).
// Depends on nothing.
interface bcc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_base;

    modport source (output valid, output char_base, input ready);
    modport sink   (input valid, input char_base, output ready);
endinterface

FILE: rtl/bcc_accum.sv
// Stage 1: masked channel sums, lit dot count and code point of one cell.
// Depends on bcc_pkg and bcc_cell_if.
module bcc_accum (
    input  logic               clk,
    input  logic               rst_n,
    bcc_cell_if.sink           dots,
    input  logic [15:0]        char_base,
    output logic               sum_valid,
    output bcc_pkg::cell_sum_t sum_data,
    input  logic               sum_ready
);

    logic               valid_reg;
    bcc_pkg::cell_sum_t data_reg;
    bcc_pkg::cell_sum_t data_next;

    // Stage advances when empty or when the next stage takes its content
    assign dots.ready = !valid_reg || sum_ready;

    // Adder trees over the eight dots
    always_comb
    begin
        data_next = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (dots.dot_mask[k])
            begin
                data_next.sum_red   = data_next.sum_red
                                    + bcc_pkg::SUM_W'(dots.red_dots[8*k +: 8]);
                data_next.sum_green = data_next.sum_green
                                    + bcc_pkg::SUM_W'(dots.green_dots[8*k +: 8]);
                data_next.sum_blue  = data_next.sum_blue
                                    + bcc_pkg::SUM_W'(dots.blue_dots[8*k +: 8]);
                data_next.count     = data_next.count + bcc_pkg::CNT_W'(1);
            end
        end
        data_next.code_point = char_base + {8'h00, dots.dot_mask};
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (dots.ready)
            valid_reg <= dots.valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (dots.ready && dots.valid)
            data_reg <= data_next;
    end

    assign sum_valid = valid_reg;
    assign sum_data  = data_reg;

endmodule

FILE: rtl/bcc_divide.sv
// Stages 2 and 3: reciprocal multiply for the averages, then decimal digits.
// Depends on bcc_pkg.
module bcc_divide (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sum_valid,
    input  bcc_pkg::cell_sum_t  sum_data,
    output logic                sum_ready,
    output logic                text_valid,
    output bcc_pkg::cell_text_t text_data,
    input  logic                text_ready
);

    logic                       avg_valid_reg;
    bcc_pkg::cell_avg_t         avg_reg;
    bcc_pkg::cell_avg_t         avg_next;
    logic                       avg_ready;
    logic [bcc_pkg::RECIP_W-1:0] rcp;
    logic [bcc_pkg::PROD_W-1:0]  prod_red;
    logic [bcc_pkg::PROD_W-1:0]  prod_green;
    logic [bcc_pkg::PROD_W-1:0]  prod_blue;
    logic                       text_valid_reg;
    bcc_pkg::cell_text_t        text_reg;
    bcc_pkg::cell_text_t        text_next;
    logic [7:0]                 red_val;
    logic [7:0]                 green_val;
    logic [7:0]                 blue_val;

    assign sum_ready = !avg_valid_reg || avg_ready;
    assign avg_ready = !text_valid_reg || text_ready;

    // Stage 2: sum times reciprocal of the count
    always_comb
    begin
        rcp        = bcc_pkg::recip(sum_data.count);
        prod_red   = bcc_pkg::PROD_W'(sum_data.sum_red)   * bcc_pkg::PROD_W'(rcp);
        prod_green = bcc_pkg::PROD_W'(sum_data.sum_green) * bcc_pkg::PROD_W'(rcp);
        prod_blue  = bcc_pkg::PROD_W'(sum_data.sum_blue)  * bcc_pkg::PROD_W'(rcp);
        avg_next.avg_red    = prod_red[bcc_pkg::RECIP_SHIFT +: 8];
        avg_next.avg_green  = prod_green[bcc_pkg::RECIP_SHIFT +: 8];
        avg_next.avg_blue   = prod_blue[bcc_pkg::RECIP_SHIFT +: 8];
        avg_next.no_dots    = (sum_data.count == '0);
        avg_next.code_point = sum_data.code_point;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            avg_valid_reg <= 1'b0;
        else if (sum_ready)
            avg_valid_reg <= sum_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sum_ready && sum_valid)
            avg_reg <= avg_next;
    end

    // Stage 3: white override, then BCD conversion
    always_comb
    begin
        red_val   = avg_reg.no_dots ? bcc_pkg::WHITE : avg_reg.avg_red;
        green_val = avg_reg.no_dots ? bcc_pkg::WHITE : avg_reg.avg_green;
        blue_val  = avg_reg.no_dots ? bcc_pkg::WHITE : avg_reg.avg_blue;
        text_next.dec_red    = bcc_pkg::to_dec(red_val);
        text_next.dec_green  = bcc_pkg::to_dec(green_val);
        text_next.dec_blue   = bcc_pkg::to_dec(blue_val);
        text_next.code_point = avg_reg.code_point;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_valid_reg <= 1'b0;
        else if (avg_ready)
            text_valid_reg <= avg_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (avg_ready && avg_valid_reg)
            text_reg <= text_next;
    end

    assign text_valid = text_valid_reg;
    assign text_data  = text_reg;

endmodule

FILE: rtl/bcc_serial.sv
// Byte sequencer: holds one converted cell and emits its text one byte per transfer.
// Depends on bcc_pkg and bcc_byte_if.
module bcc_serial (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cell_valid,
    input  bcc_pkg::cell_text_t cell_data,
    output logic                cell_ready,
    bcc_byte_if.source          text
);

    logic                        busy_reg;
    logic [bcc_pkg::IDX_W-1:0]   idx_reg;
    bcc_pkg::cell_text_t         held_reg;
    logic                        take;
    logic                        last;
    logic                        load;

    function automatic logic [7:0] digit(input logic [3:0] d);
        return bcc_pkg::CH_ZERO | {4'h0, d};
    endfunction

    assign take       = busy_reg && text.ready;
    assign last       = (idx_reg == bcc_pkg::IDX_W'(bcc_pkg::BYTES_PER_CELL - 1));
    assign cell_ready = !busy_reg || (text.ready && last);
    assign load       = cell_valid && cell_ready;

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg <= !last;
            idx_reg  <= last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            held_reg <= cell_data;
    end

    // Byte select over the cell text
    always_comb
    begin
        unique case (idx_reg)
            5'd0:    text.out_byte = bcc_pkg::CH_ESC;
            5'd1:    text.out_byte = bcc_pkg::CH_LBRK;
            5'd2:    text.out_byte = bcc_pkg::CH_THREE;
            5'd3:    text.out_byte = bcc_pkg::CH_EIGHT;
            5'd4:    text.out_byte = bcc_pkg::CH_SEMI;
            5'd5:    text.out_byte = bcc_pkg::CH_TWO;
            5'd6:    text.out_byte = bcc_pkg::CH_SEMI;
            5'd7:    text.out_byte = digit(held_reg.dec_red[11:8]);
            5'd8:    text.out_byte = digit(held_reg.dec_red[7:4]);
            5'd9:    text.out_byte = digit(held_reg.dec_red[3:0]);
            5'd10:   text.out_byte = bcc_pkg::CH_SEMI;
            5'd11:   text.out_byte = digit(held_reg.dec_green[11:8]);
            5'd12:   text.out_byte = digit(held_reg.dec_green[7:4]);
            5'd13:   text.out_byte = digit(held_reg.dec_green[3:0]);
            5'd14:   text.out_byte = bcc_pkg::CH_SEMI;
            5'd15:   text.out_byte = digit(held_reg.dec_blue[11:8]);
            5'd16:   text.out_byte = digit(held_reg.dec_blue[7:4]);
            5'd17:   text.out_byte = digit(held_reg.dec_blue[3:0]);
            5'd18:   text.out_byte = bcc_pkg::CH_M;
            5'd19:   text.out_byte = bcc_pkg::UTF8_LEAD | {4'h0, held_reg.code_point[15:12]};
            5'd20:   text.out_byte = bcc_pkg::UTF8_CONT | {2'b00, held_reg.code_point[11:6]};
            5'd21:   text.out_byte = bcc_pkg::UTF8_CONT | {2'b00, held_reg.code_point[5:0]};
            default: text.out_byte = bcc_pkg::CH_PAD;
        endcase
    end

    assign text.valid        = busy_reg;
    assign text.last_of_cell = last;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < bcc_pkg::IDX_W'(bcc_pkg::BYTES_PER_CELL)))
        else $error("byte index beyond cell length");
    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && idx_reg == '0))
        else $error("new cell does not start at its first byte");
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> (busy_reg && idx_reg == $past(idx_reg) + 1'b1))
        else $error("byte index skipped or repeated");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last && !load) |=> !busy_reg)
        else $error("sequencer busy after final byte");
`endif

endmodule

FILE: rtl/braille_cell_color_encoder.sv
// Top level of the braille cell color encoder: register, pipeline and sequencer.
// Depends on bcc_pkg, the three channel interfaces, bcc_accum, bcc_divide, bcc_serial.
//
// Usage:
//   dots  - one braille cell per transfer: dot mask plus packed red, green and
//           blue bytes of the eight dots.
//   text  - the cell's 24-byte terminal text, one byte per transfer: the color
//           escape with the average of the lit dots (white when none is lit),
//           the three-byte UTF-8 form of char_base + dot mask, two zero pads.
//           last_of_cell marks the 24th byte.
//   cfg   - writes char_base; always ready. Write only while the block is idle.
// Path: the first byte of a cell is offered once the cell has passed the sum stage,
//   the multiply stage and the digit stage and has been loaded into the sequencer.
// Throughput: bounded by the byte-wide output, which carries 24 bytes per cell; the
//   sequencer takes the next cell in the cycle its last byte transfers, and
//   three more cells can wait in the pipeline stages.
// Reset: empties all stages, char_base returns to 0x2800.
// Stall: when text is not ready the current byte holds and the stages fill,
//   then dots.ready drops; nothing is lost or repeated.
module braille_cell_color_encoder (
    input  logic       clk,
    input  logic       rst_n,
    bcc_cfg_if.sink    cfg,
    bcc_cell_if.sink   dots,
    bcc_byte_if.source text
);

    logic [15:0]         char_base_reg;
    logic                sum_valid;
    bcc_pkg::cell_sum_t  sum_data;
    logic                sum_ready;
    logic                conv_valid;
    bcc_pkg::cell_text_t conv_data;
    logic                conv_ready;

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_base_reg <= bcc_pkg::CHAR_BASE_RESET;
        else if (cfg.valid)
            char_base_reg <= cfg.char_base;
    end

    // Pipeline
    bcc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .dots      (dots),
        .char_base (char_base_reg),
        .sum_valid (sum_valid),
        .sum_data  (sum_data),
        .sum_ready (sum_ready)
    );

    bcc_divide u_divide (
        .clk        (clk),
        .rst_n      (rst_n),
        .sum_valid  (sum_valid),
        .sum_data   (sum_data),
        .sum_ready  (sum_ready),
        .text_valid (conv_valid),
        .text_data  (conv_data),
        .text_ready (conv_ready)
    );

    bcc_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (conv_valid),
        .cell_data  (conv_data),
        .cell_ready (conv_ready),
        .text       (text)
    );

endmodule

FILE: bench/braille_cell_color_encoder_tb.sv
// Self-checking testbench of braille_cell_color_encoder: drives cells and char_base writes,
// predicts each cell's 24-byte terminal text and checks every byte transfer.
// Depends on bcc_pkg, the three channel interfaces and the RTL top level.
`timescale 1ns / 100ps

// One expected text byte, with its place for reporting
typedef struct {
    logic [7:0] value;
    logic       last;
    int         cell_no;
    int         pos;
} text_byte_t;

// Predicts the text of each accepted cell and checks the output bytes in order
class cell_text_board;
    text_byte_t  due[$];
    logic [15:0] base;
    int          errors;
    int          cells_seen;
    int          bytes_ok;
    int          shown;

    function new();
        base = bcc_pkg::CHAR_BASE_RESET;
        errors = 0;
        cells_seen = 0;
        bytes_ok = 0;
        shown = 0;
    endfunction

    function int pending();
        return due.size();
    endfunction

    // Floor mean of the lit dots' bytes, white when no dot is lit
    function logic [7:0] mean_of(logic [7:0] mask, logic [63:0] plane);
        int sum;
        int cnt;
        sum = 0;
        cnt = 0;
        for (int k = 0; k < 8; k++)
        begin
            if (mask[k])
            begin
                sum += plane[8*k +: 8];
                cnt++;
            end
        end
        if (cnt == 0)
            return bcc_pkg::WHITE;
        return 8'(sum / cnt);
    endfunction

    function void note_cell(logic [7:0] mask, logic [63:0] red, logic [63:0] green,
                            logic [63:0] blue);
        logic [7:0]  txt [24];
        logic [7:0]  avg [3];
        logic [15:0] cp;
        text_byte_t  e;
        avg[0] = mean_of(mask, red);
        avg[1] = mean_of(mask, green);
        avg[2] = mean_of(mask, blue);
        cp = base + {8'h00, mask};
        for (int i = 0; i < 24; i++)
            txt[i] = bcc_pkg::CH_PAD;
        // ESC[38;2;
        txt[0] = bcc_pkg::CH_ESC;
        txt[1] = bcc_pkg::CH_LBRK;
        txt[2] = bcc_pkg::CH_THREE;
        txt[3] = bcc_pkg::CH_EIGHT;
        txt[4] = bcc_pkg::CH_SEMI;
        txt[5] = bcc_pkg::CH_TWO;
        txt[6] = bcc_pkg::CH_SEMI;
        // three zero-padded decimals separated by semicolons
        for (int c = 0; c < 3; c++)
        begin
            txt[7 + 4*c] = bcc_pkg::CH_ZERO + 8'(avg[c] / 100);
            txt[8 + 4*c] = bcc_pkg::CH_ZERO + 8'((avg[c] / 10) % 10);
            txt[9 + 4*c] = bcc_pkg::CH_ZERO + 8'(avg[c] % 10);
            if (c < 2)
                txt[10 + 4*c] = bcc_pkg::CH_SEMI;
        end
        txt[18] = bcc_pkg::CH_M;
        // always the three-byte form of the code point
        txt[19] = bcc_pkg::UTF8_LEAD | {4'h0, cp[15:12]};
        txt[20] = bcc_pkg::UTF8_CONT | {2'b00, cp[11:6]};
        txt[21] = bcc_pkg::UTF8_CONT | {2'b00, cp[5:0]};
        for (int i = 0; i < bcc_pkg::BYTES_PER_CELL; i++)
        begin
            e.value = txt[i];
            e.last = (i == bcc_pkg::BYTES_PER_CELL - 1);
            e.cell_no = cells_seen;
            e.pos = i;
            due.push_back(e);
        end
        cells_seen++;
    endfunction

    function void check_byte(logic [7:0] value, logic last);
        text_byte_t e;
        if (due.size() == 0)
        begin
            errors++;
            if (shown < 20)
                $display("%0t: unexpected text byte %02h last %0b", $time, value, last);
            shown++;
            return;
        end
        e = due.pop_front();
        if (value !== e.value)
        begin
            errors++;
            if (shown < 20)
                $display("%0t: cell %0d byte %0d out_byte expected %02h actual %02h",
                         $time, e.cell_no, e.pos, e.value, value);
            shown++;
        end
        else if (last !== e.last)
        begin
            errors++;
            if (shown < 20)
                $display("%0t: cell %0d byte %0d last_of_cell expected %0b actual %0b",
                         $time, e.cell_no, e.pos, e.last, last);
            shown++;
        end
        else
            bytes_ok++;
    endfunction
endclass

module braille_cell_color_encoder_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 200;
    localparam int IDLE_PCT     = 21;

    logic clk;
    logic rst_n;

    bcc_cfg_if  cfg_if ();
    bcc_cell_if dots_if ();
    bcc_byte_if text_if ();

    braille_cell_color_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .dots  (dots_if),
        .text  (text_if)
    );

    cell_text_board board = new();

    bit gaps_on   = 1'b1;
    bit stall_req = 1'b0;
    int stall_left = 0;
    int cycles    = 0;
    int base_writes = 0;

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still due", cycles, board.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random backpressure, plus one long hold-off on request
    initial
    begin
        text_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                text_if.ready <= 1'b0;
                stall_left++;
                if (stall_left >= STALL_CYCLES)
                begin
                    stall_req = 1'b0;
                    stall_left = 0;
                end
            end
            else
                text_if.ready <= !(gaps_on && ($urandom_range(0, 99) < IDLE_PCT));
        end
    end

    // Check every byte transfer
    always @(posedge clk)
    begin
        if (rst_n && text_if.valid && text_if.ready)
            board.check_byte(text_if.out_byte, text_if.last_of_cell);
    end

    // Offer one cell, with random gaps before it, and note it on transfer
    task automatic send_cell(input logic [7:0] mask, input logic [63:0] red,
                             input logic [63:0] green, input logic [63:0] blue);
        @(negedge clk);
        while (gaps_on && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            dots_if.valid <= 1'b0;
            @(negedge clk);
        end
        dots_if.valid      <= 1'b1;
        dots_if.dot_mask   <= mask;
        dots_if.red_dots   <= red;
        dots_if.green_dots <= green;
        dots_if.blue_dots  <= blue;
        do @(posedge clk); while (!dots_if.ready);
        board.note_cell(mask, red, green, blue);
    endtask

    // Random color plane; bright planes push the sums toward the top of the range
    function automatic logic [63:0] rand_plane(input bit bright);
        logic [63:0] p;
        for (int k = 0; k < 8; k++)
            p[8*k +: 8] = bright ? 8'(248 + $urandom_range(0, 7)) : 8'($urandom);
        return p;
    endfunction

    task automatic send_random_cell();
        logic [7:0] mask;
        bit         bright;
        case ($urandom_range(0, 9))
            0:       mask = 8'h00;
            1:       mask = 8'hFF;
            default: mask = 8'($urandom);
        endcase
        bright = ($urandom_range(0, 3) == 0);
        send_cell(mask, rand_plane(bright), rand_plane(bright), rand_plane(bright));
    endtask

    // Stop offering and wait until every expected byte has transferred
    task automatic drain_text();
        @(negedge clk);
        dots_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // char_base write; only called with the block idle
    task automatic write_base(input logic [15:0] value);
        @(negedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.char_base <= value;
        do @(posedge clk); while (!cfg_if.ready);
        board.base = value;
        base_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        rst_n              = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.char_base   = '0;
        dots_if.valid      = 1'b0;
        dots_if.dot_mask   = '0;
        dots_if.red_dots   = '0;
        dots_if.green_dots = '0;
        dots_if.blue_dots  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset char_base: no lit dot, full and empty colors, each single dot
        send_cell(8'h00, rand_plane(0), rand_plane(0), rand_plane(0));
        send_cell(8'hFF, '1, '1, '1);
        send_cell(8'hFF, '0, '0, '0);
        for (int k = 0; k < 8; k++)
            send_cell(8'(1 << k), rand_plane(0), rand_plane(0), rand_plane(0));
        // counts that are not powers of two, then four alternating dots
        send_cell(8'h07, {8{8'hFE}}, '1, {8{8'h01}});
        send_cell(8'h1F, rand_plane(1), rand_plane(1), rand_plane(1));
        send_cell(8'h3F, rand_plane(0), rand_plane(0), rand_plane(0));
        send_cell(8'h7F, {8{8'hFE}}, {8{8'hFE}}, rand_plane(1));
        send_cell(8'hAA, rand_plane(0), rand_plane(0), rand_plane(0));

        // char_base 0: smallest code points still in three-byte form
        drain_text();
        write_base(16'h0000);
        send_cell(8'h00, rand_plane(0), rand_plane(0), rand_plane(0));
        send_cell(8'hFF, rand_plane(0), rand_plane(0), rand_plane(0));
        repeat (10) send_random_cell();

        // char_base 0xFFFF: code point wraps past 0xFFFF
        drain_text();
        write_base(16'hFFFF);
        send_cell(8'h01, rand_plane(0), rand_plane(0), rand_plane(0));
        send_cell(8'hFF, rand_plane(1), rand_plane(1), rand_plane(1));
        send_cell(8'h00, '0, '0, '0);
        repeat (10) send_random_cell();

        // random char_base, back-to-back on both sides
        drain_text();
        write_base(16'($urandom));
        gaps_on = 1'b0;
        repeat (30) send_random_cell();
        gaps_on = 1'b1;

        // long output hold-off while cells keep coming: input must stall
        stall_req = 1'b1;
        repeat (12) send_random_cell();

        // sender pauses until all text is out, then back to the reset value
        drain_text();
        write_base(bcc_pkg::CHAR_BASE_RESET);
        repeat (60) send_random_cell();

        drain_text();
        repeat (10) @(posedge clk);

        $display("covered %0d cells, %0d bytes matched, %0d char_base writes incl. 0 and 0xFFFF",
                 board.cells_seen, board.bytes_ok, base_writes);
        $display("with random gaps, a gap-free stretch and a %0d-cycle output hold-off",
                 STALL_CYCLES);
        if (board.errors == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
